[design/pfa_pkg.sv]
`default_nettype none

package pfa_pkg;

  // fixed field widths of the channels
  localparam int unsigned FRAME_W = 5;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 6;

  // operation codes
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_TOUCH  = 2'd2,
    KIND_VICTIM = 2'd3
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OWNER,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

[design/pfa_chan_if.sv]
`default_nettype none

// request channel
interface pfa_in_if
  import pfa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  kind_e                kind;
  logic [FRAME_W-1:0]   frame;
  logic [OWNER_W-1:0]   owner;
  logic [STAMP_W-1:0]   stamp;

  modport source (output valid, kind, frame, owner, stamp, input ready);
  modport sink   (input valid, kind, frame, owner, stamp, output ready);
endinterface

// result channel
interface pfa_out_if
  import pfa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [FRAME_W-1:0]   frame_out;
  logic                 found;
  logic                 frame_in_use;
  logic [COUNT_W-1:0]   free_count;
  logic [OWNER_W-1:0]   victim_owner;

  modport source (output valid, frame_out, found, frame_in_use, free_count, victim_owner,
                  input ready);
  modport sink   (input valid, frame_out, found, frame_in_use, free_count, victim_owner,
                  output ready);
endinterface

`default_nettype wire

[design/pfa_ctrl.sv]
`default_nettype none

module pfa_ctrl
  import pfa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire kind_e in_kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output cmd_t       cmd_o,
  input  wire sts_t  sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   finish;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_ALLOC || in_kind_i == KIND_VICTIM) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_OWNER;
      ST_OWNER: state_d = ST_FINISH;
      ST_FINISH: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    cmd_o.start  = accept;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.finish = finish;
  end

  // result valid flag of the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[design/pfa_datapath.sv]
`default_nettype none

module pfa_datapath
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire kind_e              kind_i,
  input  wire logic [FRAME_W-1:0] frame_i,
  input  wire logic [OWNER_W-1:0] owner_i,
  input  wire logic [STAMP_W-1:0] stamp_i,
  output logic [FRAME_W-1:0]      frame_out_o,
  output logic                    found_o,
  output logic                    frame_in_use_o,
  output logic [COUNT_W-1:0]      free_count_o,
  output logic [OWNER_W-1:0]      victim_owner_o
);

  localparam int unsigned IW  = $clog2(NUM_FRAMES);
  localparam int unsigned FTW = $clog2(NUM_FRAMES + 1);

  // frame state
  logic [NUM_FRAMES-1:0] used_q, used_d;
  logic [FTW-1:0]        ftotal_q, ftotal_d;
  logic [OWNER_W-1:0]    owner_mem [NUM_FRAMES];
  logic [STAMP_W-1:0]    stamp_mem [NUM_FRAMES];

  // latched request
  kind_e              kind_q;
  logic [FRAME_W-1:0] frame_q;
  logic [OWNER_W-1:0] owner_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               in_range_q;
  logic               was_used_q;

  // scan pipeline
  logic [IW-1:0]      scan_q;
  logic               pipe_vld_q;
  logic               pipe_used_q;
  logic [IW-1:0]      pipe_idx_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic [OWNER_W-1:0] owner_rd_q;
  logic               have_q, have_d;
  logic [IW-1:0]      best_q, best_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;

  // output register
  logic [FRAME_W-1:0] frame_out_q;
  logic               found_q;
  logic               frame_in_use_q;
  logic [COUNT_W-1:0] free_count_q;
  logic [OWNER_W-1:0] victim_owner_q;

  logic          in_range;
  logic [IW-1:0] in_idx;
  logic [IW-1:0] fidx;
  logic          is_alloc;
  logic          res_found;
  logic          stamp_we;
  logic [IW-1:0] stamp_wa;
  logic          owner_we;

  assign in_range = 32'(frame_i) < 32'(NUM_FRAMES);
  assign in_idx   = IW'(frame_i);
  assign fidx     = IW'(frame_q);
  assign is_alloc = (kind_q == KIND_ALLOC);

  assign sts_o.scan_last = (scan_q == IW'(NUM_FRAMES - 1));

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q     <= kind_i;
      frame_q    <= frame_i;
      owner_q    <= owner_i;
      stamp_q    <= stamp_i;
      in_range_q <= in_range;
      was_used_q <= in_range && used_q[in_idx];
    end
  end

  // scan index and candidate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      pipe_vld_q <= 1'b0;
      have_q     <= 1'b0;
    end else begin
      pipe_vld_q <= cmd_i.scan;
      have_q     <= have_d;
      if (cmd_i.start) begin
        scan_q <= '0;
      end else if (cmd_i.scan) begin
        scan_q <= scan_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_used_q  <= used_q[scan_q];
    pipe_idx_q   <= scan_q;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
  end

  // lowest free frame for allocate, oldest used frame for victim
  always_comb begin
    have_d       = have_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    if (cmd_i.start) begin
      have_d = 1'b0;
    end else if (pipe_vld_q) begin
      if (is_alloc) begin
        if (!have_q && !pipe_used_q) begin
          have_d = 1'b1;
          best_d = pipe_idx_q;
        end
      end else if (pipe_used_q && (!have_q || stamp_rd_q < best_stamp_q)) begin
        have_d       = 1'b1;
        best_d       = pipe_idx_q;
        best_stamp_d = stamp_rd_q;
      end
    end
  end

  // state update at the end of an operation
  always_comb begin
    used_d   = used_q;
    ftotal_d = ftotal_q;
    if (cmd_i.finish) begin
      case (kind_q)
        KIND_ALLOC: begin
          if (have_q) begin
            used_d[best_q] = 1'b1;
            if (ftotal_q != '0) begin
              ftotal_d = ftotal_q - FTW'(1);
            end
          end
        end
        KIND_FREE: begin
          if (was_used_q) begin
            used_d[fidx] = 1'b0;
            ftotal_d     = ftotal_q + FTW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      ftotal_q <= FTW'(NUM_FRAMES);
    end else begin
      used_q   <= used_d;
      ftotal_q <= ftotal_d;
    end
  end

  // table writes
  assign stamp_we = cmd_i.finish && ((is_alloc && have_q) ||
                                     (kind_q == KIND_TOUCH && in_range_q));
  assign stamp_wa = is_alloc ? best_q : fidx;
  assign owner_we = cmd_i.finish && is_alloc && have_q;

  // stamp memory, read at the scan index
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= stamp_q;
    end
    stamp_rd_q <= stamp_mem[scan_q];
  end

  // owner memory, read at the chosen frame
  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_mem[best_q] <= owner_q;
    end
    owner_rd_q <= owner_mem[best_q];
  end

  // result register
  assign res_found = have_q && (is_alloc || kind_q == KIND_VICTIM);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q        <= res_found;
      frame_out_q    <= res_found ? FRAME_W'(best_q) : '0;
      frame_in_use_q <= was_used_q;
      free_count_q   <= COUNT_W'(ftotal_d);
      if (!res_found) begin
        victim_owner_q <= '0;
      end else if (is_alloc) begin
        victim_owner_q <= owner_q;
      end else begin
        victim_owner_q <= owner_rd_q;
      end
    end
  end

  assign frame_out_o    = frame_out_q;
  assign found_o        = found_q;
  assign frame_in_use_o = frame_in_use_q;
  assign free_count_o   = free_count_q;
  assign victim_owner_o = victim_owner_q;

endmodule

`default_nettype wire

[design/page_frame_allocator_lru_core.sv]
// channel  dir  handshake      payload
// in_i     in   valid / ready  kind, frame, owner, stamp
// out_o    out  valid / ready  frame_out, found, frame_in_use, free_count, victim_owner
//
// allocate and victim scan every frame one per cycle, then take a drain step and an
// owner read step before the finishing step registers the result
// free and touch go straight to the finishing step; next transfer only after it
// one operation is in flight at a time
// reset clears all used bits and sets the free count to NUM_FRAMES
// a result waiting on out_o holds the block in its final step until it is taken
`default_nettype none

module page_frame_allocator_lru_core
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfa_in_if.sink     in_i,
  pfa_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (in_i.kind),
    .frame_i        (in_i.frame),
    .owner_i        (in_i.owner),
    .stamp_i        (in_i.stamp),
    .frame_out_o    (out_o.frame_out),
    .found_o        (out_o.found),
    .frame_in_use_o (out_o.frame_in_use),
    .free_count_o   (out_o.free_count),
    .victim_owner_o (out_o.victim_owner)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // one operation at a time: busy right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while an operation is in flight");

  // a new result appears only from the finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.finish))
    else $error("result valid without a finishing step");

  // scanning and finishing never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.scan && cmd.finish))
    else $error("scan and finish in the same cycle");

  // no frame found means zero frame and owner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.frame_out == '0 && out_o.victim_owner == '0))
    else $error("frame or owner set without a found frame");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pfa_pkg::*;

  localparam int unsigned NUM_FRAMES   = 32;
  localparam int unsigned RANDOM_ITEMS = 1420;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned MAX_REPORTS  = 40;

  // one result transfer as the checker sees it
  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               found;
    logic               frame_in_use;
    logic [COUNT_W-1:0] free_count;
    logic [OWNER_W-1:0] victim_owner;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfa_in_if  in_if ();
  pfa_out_if out_if ();

  page_frame_allocator_lru_core #(
    .NUM_FRAMES(NUM_FRAMES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow copy of the allocator tables
  logic               frame_used  [NUM_FRAMES];
  logic [OWNER_W-1:0] frame_owner [NUM_FRAMES];
  logic [STAMP_W-1:0] frame_stamp [NUM_FRAMES];
  int unsigned        free_frames;

  frame_result_t pending_results[$];
  int unsigned   err_count;
  int unsigned   result_count;
  int unsigned   idle_cycles;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (err_count < MAX_REPORTS)
      $display("[%0t] ERROR result %0d: %s", $time, result_count, msg);
    err_count++;
  endtask

  // apply one operation to the shadow tables and return what the block should answer
  function automatic frame_result_t predict_frame_op(input kind_e k,
                                                     input logic [FRAME_W-1:0] fr,
                                                     input logic [OWNER_W-1:0] own,
                                                     input logic [STAMP_W-1:0] stp);
    frame_result_t r;
    bit            in_range;
    bit            have;
    logic [STAMP_W-1:0] best_stamp;
    r          = '0;
    in_range   = (fr < NUM_FRAMES);
    have       = 1'b0;
    best_stamp = '0;
    r.frame_in_use = in_range ? frame_used[fr] : 1'b0;
    case (k)
      KIND_ALLOC: begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!frame_used[i]) begin
            frame_used[i]  = 1'b1;
            frame_owner[i] = own;
            frame_stamp[i] = stp;
            if (free_frames > 0) free_frames--;
            r.frame_out    = i[FRAME_W-1:0];
            r.found        = 1'b1;
            r.victim_owner = own;
            break;
          end
        end
      end
      KIND_FREE: begin
        if (in_range && frame_used[fr]) begin
          frame_used[fr] = 1'b0;
          free_frames++;
        end
      end
      KIND_TOUCH: begin
        if (in_range) frame_stamp[fr] = stp;
      end
      default: begin
        // oldest stamp wins, strict compare keeps the lowest index on ties
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (frame_used[i] && (!have || frame_stamp[i] < best_stamp)) begin
            have           = 1'b1;
            best_stamp     = frame_stamp[i];
            r.frame_out    = i[FRAME_W-1:0];
            r.found        = 1'b1;
            r.victim_owner = frame_owner[i];
          end
        end
      end
    endcase
    r.free_count = free_frames[COUNT_W-1:0];
    return r;
  endfunction

  // send one request; entered and left just after a falling edge
  task automatic send_op(input kind_e k, input logic [FRAME_W-1:0] fr,
                         input logic [OWNER_W-1:0] own, input logic [STAMP_W-1:0] stp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.kind  = k;
    in_if.frame = fr;
    in_if.owner = own;
    in_if.stamp = stp;
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_frame_op(k, fr, own, stp));
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(7);
      4:       return 32'd1000000000;
      default: return $urandom;
    endcase
  endfunction

  // mostly a frame in use, otherwise any index
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned used_list[$];
    for (int i = 0; i < NUM_FRAMES; i++)
      if (frame_used[i]) used_list.push_back(i);
    if (used_list.size() != 0 && $urandom_range(99) < 85)
      return FRAME_W'(used_list[$urandom_range(used_list.size() - 1)]);
    return FRAME_W'($urandom_range(31));
  endfunction

  // corner cases: empty table, ties, extremes, double free
  task automatic test_directed();
    send_op(KIND_VICTIM, 5'd0, 8'd0, '0);
    send_op(KIND_FREE, 5'd5, 8'd0, '0);
    send_op(KIND_TOUCH, 5'd7, 8'd0, 32'hFFFF_FFFF);
    send_op(KIND_ALLOC, 5'd31, 8'd0, 32'hFFFF_FFFF);
    send_op(KIND_ALLOC, 5'd0, 8'd255, '0);
    send_op(KIND_ALLOC, 5'd0, 8'hA5, '0);
    send_op(KIND_VICTIM, 5'd31, 8'd255, '1);
    send_op(KIND_TOUCH, 5'd1, 8'd0, 32'hFFFF_FFFF);
    send_op(KIND_VICTIM, 5'd0, 8'd0, '0);
    send_op(KIND_TOUCH, 5'd2, 8'd0, 32'd1000000000);
    send_op(KIND_VICTIM, 5'd2, 8'd0, '0);
    send_op(KIND_FREE, 5'd0, 8'd0, '0);
    send_op(KIND_ALLOC, 5'd0, 8'h5A, 32'd1);
    send_op(KIND_VICTIM, 5'd0, 8'd0, '0);
    send_op(KIND_FREE, 5'd31, 8'hFF, '1);
    send_op(KIND_TOUCH, 5'd31, 8'd0, '0);
    send_op(KIND_FREE, 5'd1, 8'd0, '0);
    send_op(KIND_FREE, 5'd1, 8'd0, '0);
    send_op(KIND_FREE, 5'd0, 8'd0, '0);
    send_op(KIND_FREE, 5'd2, 8'd0, '0);
    send_op(KIND_VICTIM, 5'd0, 8'd0, '0);
  endtask

  // fill every frame, allocate into a full table, then free all in random order
  task automatic test_fill_and_drain();
    int unsigned order[NUM_FRAMES];
    int unsigned j;
    int unsigned tmp;
    repeat (2) begin
      while (free_frames > 0)
        send_op(KIND_ALLOC, FRAME_W'($urandom_range(31)), OWNER_W'($urandom_range(255)),
                pick_stamp());
      send_op(KIND_ALLOC, FRAME_W'($urandom_range(31)), OWNER_W'($urandom_range(255)),
              pick_stamp());
      send_op(KIND_VICTIM, FRAME_W'($urandom_range(31)), 8'd0, '0);
      repeat (4) send_op(KIND_TOUCH, FRAME_W'($urandom_range(31)), 8'd0, '0);
      send_op(KIND_VICTIM, FRAME_W'($urandom_range(31)), 8'd0, '0);
      for (int i = 0; i < NUM_FRAMES; i++) order[i] = i;
      for (int i = NUM_FRAMES - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < NUM_FRAMES; i++) begin
        send_op(KIND_FREE, FRAME_W'(order[i]), OWNER_W'($urandom_range(255)), $urandom);
        if (i % 4 == 3) send_op(KIND_VICTIM, FRAME_W'($urandom_range(31)), 8'd0, '0);
      end
      send_op(KIND_VICTIM, FRAME_W'($urandom_range(31)), 8'd0, '0);
    end
  endtask

  // random mix, alternating between filling and emptying phases
  task automatic test_random();
    int unsigned alloc_pct;
    int unsigned free_pct;
    int unsigned roll;
    alloc_pct = 20;
    free_pct  = 30;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) begin
        alloc_pct = ((n / 200) % 2 == 1) ? 55 : 20;
        free_pct  = (alloc_pct == 55) ? 15 : 30;
      end
      // stretch with no idling on either side
      if (n == 600) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      if (n == 900) begin
        send_idle_pct = 10;
        stall_pct     = 10;
      end
      if (n == 800) wait_for_results();
      roll = $urandom_range(99);
      if (roll < alloc_pct)
        send_op(KIND_ALLOC, FRAME_W'($urandom_range(31)), OWNER_W'($urandom_range(255)),
                pick_stamp());
      else if (roll < alloc_pct + free_pct)
        send_op(KIND_FREE, pick_frame(), OWNER_W'($urandom_range(255)), $urandom);
      else if (roll < alloc_pct + free_pct + 20)
        send_op(KIND_TOUCH, pick_frame(), OWNER_W'($urandom_range(255)), pick_stamp());
      else
        send_op(KIND_VICTIM, FRAME_W'($urandom_range(31)), OWNER_W'($urandom_range(255)),
                $urandom);
    end
  endtask

  // result side stalls
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.frame_out    = out_if.frame_out;
      got.found        = out_if.found;
      got.frame_in_use = out_if.frame_in_use;
      got.free_count   = out_if.free_count;
      got.victim_owner = out_if.victim_owner;
      if (pending_results.size() == 0) begin
        flag_error("result transfer with no request outstanding");
      end else begin
        exp = pending_results.pop_front();
        if (got.frame_out !== exp.frame_out)
          flag_error($sformatf("frame_out %0d, expected %0d", got.frame_out, exp.frame_out));
        if (got.found !== exp.found)
          flag_error($sformatf("found %0b, expected %0b", got.found, exp.found));
        if (got.frame_in_use !== exp.frame_in_use)
          flag_error($sformatf("frame_in_use %0b, expected %0b",
                               got.frame_in_use, exp.frame_in_use));
        if (got.free_count !== exp.free_count)
          flag_error($sformatf("free_count %0d, expected %0d",
                               got.free_count, exp.free_count));
        if (got.victim_owner !== exp.victim_owner)
          flag_error($sformatf("victim_owner %0d, expected %0d",
                               got.victim_owner, exp.victim_owner));
      end
      result_count++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_ALLOC;
    in_if.frame   = '0;
    in_if.owner   = '0;
    in_if.stamp   = '0;
    out_if.ready  = 1'b0;
    err_count     = 0;
    result_count  = 0;
    idle_cycles   = 0;
    send_idle_pct = 10;
    stall_pct     = 10;
    free_frames   = NUM_FRAMES;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_used[i]  = 1'b0;
      frame_owner[i] = '0;
      frame_stamp[i] = '0;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    wait_for_results();
    test_fill_and_drain();
    test_random();

    // drain, then allow for the longest scan
    wait_for_results();
    repeat (NUM_FRAMES + 8) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/pfa_pkg.sv
design/pfa_chan_if.sv
design/pfa_ctrl.sv
design/pfa_datapath.sv
design/page_frame_allocator_lru_core.sv
bench/tb_top.sv
